/* hdl/bsfb_pkg.sv */
// Shared types, register codes and reset values for the byte-stuffed frame builder.
package bsfb_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_BYTE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BYTE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_BYTE = 3'd4;

    localparam logic [7:0] FLAG_BYTE_RST    = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE_RST  = 8'h7D;
    localparam logic [7:0] ESCAPE_MASK_RST  = 8'h20;
    localparam logic [7:0] ADDRESS_BYTE_RST = 8'h03;
    localparam logic [7:0] CONTROL_BYTE_RST = 8'h00;

    // One payload word as it waits in the queue, already classified.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;
    } t_item;

    // Current register settings seen by the back end.
    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] escape_mask;
        logic [7:0] address_byte;
        logic [7:0] control_byte;
    } t_cfg;

    // Queue status seen by front and back.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_START,
        ST_ADDR,
        ST_CTRL,
        ST_CHECK,
        ST_DATA,
        ST_CLOSE
    } t_step;

endpackage

/* hdl/bsfb_front.sv */
// Front end: accepts payload words and marks the first word of each frame.
module bsfb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  bsfb_pkg::t_q_status i_q_status,
    output logic               o_push,
    output bsfb_pkg::t_item    o_item
);
    import bsfb_pkg::*;

    logic r_in_frame;
    logic n_in_frame;

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    assign o_item.data  = i_data_byte;
    assign o_item.last  = i_last_byte;
    assign o_item.first = !r_in_frame;

    // A frame stays open from its first word until its last word.
    always_comb begin
        n_in_frame = r_in_frame;
        if (o_push) begin
            n_in_frame = !i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
        end
    end

endmodule

/* hdl/bsfb_queue.sv */
// Short queue that decouples the front end from the back end.
module bsfb_queue #(
    parameter int unsigned DEPTH = bsfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bsfb_pkg::t_item     i_item,
    input  logic                i_pop,
    output bsfb_pkg::t_item     o_head,
    output bsfb_pkg::t_q_status o_status
);
    import bsfb_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* hdl/bsfb_back.sv */
// Back end: sequences header, stuffed bytes and closing flag into the output register.
module bsfb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsfb_pkg::t_cfg      i_cfg,
    input  bsfb_pkg::t_item     i_head,
    input  bsfb_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_out_last
);
    import bsfb_pkg::*;

    t_step      r_step;
    t_step      n_step;
    logic       r_esc;
    logic       n_esc;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       r_last;
    logic       n_last;

    t_step      cur_step;
    logic       emit;
    logic [7:0] src_byte;
    logic       stuff_hit;
    t_step      adv_step;
    logic       adv_pop;

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_START;
            r_esc   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_esc   <= n_esc;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    always_comb begin
        emit     = !i_q_status.empty && (!r_valid || i_ready);
        cur_step = r_step;
        src_byte = i_head.data;
        adv_step = r_step;
        adv_pop  = 1'b0;
        n_step   = r_step;
        n_esc    = r_esc;
        n_valid  = r_valid && !i_ready;
        n_byte   = r_byte;
        n_last   = r_last;
        o_pop    = 1'b0;

        if (r_step == ST_START && !i_head.first) begin
            cur_step = ST_DATA;
        end

        case (cur_step)
            ST_ADDR:  src_byte = i_cfg.address_byte;
            ST_CTRL:  src_byte = i_cfg.control_byte;
            ST_CHECK: src_byte = i_cfg.address_byte ^ i_cfg.control_byte;
            default:  src_byte = i_head.data;
        endcase
        stuff_hit = (src_byte == i_cfg.flag_byte) || (src_byte == i_cfg.escape_byte);

        // Where the sequence goes once the current field is fully sent.
        case (cur_step)
            ST_START: adv_step = ST_ADDR;
            ST_ADDR:  adv_step = ST_CTRL;
            ST_CTRL:  adv_step = ST_CHECK;
            ST_CHECK: adv_step = ST_DATA;
            ST_DATA: begin
                adv_step = i_head.last ? ST_CLOSE : ST_START;
                adv_pop  = !i_head.last;
            end
            ST_CLOSE: begin
                adv_step = ST_START;
                adv_pop  = 1'b1;
            end
            default:  adv_step = ST_START;
        endcase

        if (emit) begin
            n_valid = 1'b1;
            n_last  = 1'b0;
            if (cur_step == ST_START || cur_step == ST_CLOSE) begin
                n_byte = i_cfg.flag_byte;
                n_last = (cur_step == ST_CLOSE);
                n_step = adv_step;
                o_pop  = adv_pop;
            end else if (r_esc) begin
                n_byte = src_byte ^ i_cfg.escape_mask;
                n_esc  = 1'b0;
                n_step = adv_step;
                o_pop  = adv_pop;
            end else if (stuff_hit) begin
                n_byte = i_cfg.escape_byte;
                n_esc  = 1'b1;
                n_step = cur_step;
            end else begin
                n_byte = src_byte;
                n_step = adv_step;
                o_pop  = adv_pop;
            end
        end
    end

endmodule

/* hdl/byte_stuffed_frame_builder_core.sv */
// Top level of the byte-stuffed frame builder: config registers, front end, queue and back end.
// Accepted payload words are queued; their line words leave through the output register.
// Throughput: one line word per cycle unless the line stalls or the queue is empty; a payload
// word is one line word, two if escaped, the header four to seven and the closing flag one.
// Input acceptance runs ahead of the line as long as the queue has room.
// Reset (synchronous, active low) restores the register defaults and empties the queue.
module byte_stuffed_frame_builder_core #(
    parameter int unsigned QUEUE_DEPTH = bsfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_out_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bsfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import bsfb_pkg::*;

    t_cfg      r_cfg;
    t_cfg      n_cfg;
    t_item     push_item;
    t_item     head_item;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Configuration writes are always taken; indexes beyond the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FLAG_BYTE:    n_cfg.flag_byte    = i_cfg_data;
                CFG_ESCAPE_BYTE:  n_cfg.escape_byte  = i_cfg_data;
                CFG_ESCAPE_MASK:  n_cfg.escape_mask  = i_cfg_data;
                CFG_ADDRESS_BYTE: n_cfg.address_byte = i_cfg_data;
                CFG_CONTROL_BYTE: n_cfg.control_byte = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte    <= FLAG_BYTE_RST;
            r_cfg.escape_byte  <= ESCAPE_BYTE_RST;
            r_cfg.escape_mask  <= ESCAPE_MASK_RST;
            r_cfg.address_byte <= ADDRESS_BYTE_RST;
            r_cfg.control_byte <= CONTROL_BYTE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The front tags each word with whether it opens a frame.
    bsfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_item      (push_item)
    );

    bsfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    // The back walks each queued word through header, stuffing and closing flag.
    bsfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (head_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

/* tb/byte_stuffed_frame_checker.sv */
// Line checker for the byte-stuffed frame builder: predicts every line word and compares it.
module byte_stuffed_frame_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic [7:0]                     o_out_byte,
    input  logic                           o_out_last,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [bsfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending
);
    import bsfb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } t_line_word;

    // Line words still owed by the block, oldest first.
    t_line_word expected_line_q[$];

    logic [7:0] flag_r;
    logic [7:0] esc_r;
    logic [7:0] mask_r;
    logic [7:0] addr_r;
    logic [7:0] ctrl_r;
    logic       in_frame;
    t_line_word head;
    int         line_count;
    int         mismatch_count;

    function automatic void push_line_word(input logic [7:0] octet, input logic last);
        expected_line_q.push_back({octet, last});
    endfunction

    // A byte equal to the flag or the escape goes out as escape, then byte XOR mask.
    function automatic void push_stuffed(input logic [7:0] octet);
        if (octet == flag_r || octet == esc_r) begin
            push_line_word(esc_r, 1'b0);
            push_line_word(octet ^ mask_r, 1'b0);
        end else begin
            push_line_word(octet, 1'b0);
        end
    endfunction

    function automatic void predict_frame_words(input logic [7:0] data, input logic last);
        if (!in_frame) begin
            push_line_word(flag_r, 1'b0);
            push_stuffed(addr_r);
            push_stuffed(ctrl_r);
            push_stuffed(addr_r ^ ctrl_r);
            in_frame = 1'b1;
        end
        push_stuffed(data);
        if (last) begin
            push_line_word(flag_r, 1'b1);
            in_frame = 1'b0;
        end
    endfunction

    initial begin
        line_count     = 0;
        mismatch_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flag_r   = FLAG_BYTE_RST;
            esc_r    = ESCAPE_BYTE_RST;
            mask_r   = ESCAPE_MASK_RST;
            addr_r   = ADDRESS_BYTE_RST;
            ctrl_r   = CONTROL_BYTE_RST;
            in_frame = 1'b0;
            expected_line_q.delete();
        end else begin
            // Results leaving now belong to words accepted earlier, so check them first.
            if (o_valid && i_ready) begin
                line_count++;
                if (expected_line_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("line word %0d unexpected: byte %02h last %0b",
                                 line_count, o_out_byte, o_out_last);
                    end
                end else begin
                    head = expected_line_q.pop_front();
                    if (o_out_byte !== head.octet || o_out_last !== head.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("line word %0d: expected %02h/%0b, got %02h/%0b",
                                     line_count, head.octet, head.last,
                                     o_out_byte, o_out_last);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FLAG_BYTE:    flag_r = i_cfg_data;
                    CFG_ESCAPE_BYTE:  esc_r  = i_cfg_data;
                    CFG_ESCAPE_MASK:  mask_r = i_cfg_data;
                    CFG_ADDRESS_BYTE: addr_r = i_cfg_data;
                    CFG_CONTROL_BYTE: ctrl_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                predict_frame_words(i_data_byte, i_last_byte);
            end
        end
        o_pending    <= expected_line_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

/* tb/byte_stuffed_frame_builder_core_tb.sv */
// Testbench top for the byte-stuffed frame builder: stimulus, line stalls and the verdict.
module byte_stuffed_frame_builder_core_tb;
    import bsfb_pkg::*;

    // Cycle limit for the whole run, with a wide margin over the slowest legal run.
    localparam int LIMIT_CYCLES    = 400000;
    // Quiet cycles after the last expected word.
    localparam int SETTLE_CYCLES   = 12;
    // Length of the one long line stall that fills the queue and stalls the input.
    localparam int HOLD_CYCLES     = 120;
    localparam int HOLD_AFTER      = 250;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 75;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_last_byte = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_out_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FLAG_BYTE;
    logic [7:0]           i_cfg_data  = 8'h00;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int words_sent  = 0;
    int burst_left  = 0;

    // Copies of the current register values, used only to bias the payload toward
    // bytes that need stuffing or that collide after the mask is applied.
    logic [7:0] cur_flag = FLAG_BYTE_RST;
    logic [7:0] cur_esc  = ESCAPE_BYTE_RST;
    logic [7:0] cur_mask = ESCAPE_MASK_RST;

    byte_stuffed_frame_builder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    byte_stuffed_frame_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a word that never comes ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL byte_stuffed_frame_builder_core");
            $finish;
        end
    end

    // Offers one payload word and returns at the edge where it is accepted. Valid is
    // left high so that the next word can follow without a bubble; it is only lowered
    // when a gap really follows.
    task automatic send_word(input logic [7:0] data, input logic last);
        int gap;
        int r;
        if (burst_left == 0) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                gap = 0;
            end else if (r < 8) begin
                gap = $urandom_range(1, 3);
            end else begin
                gap = $urandom_range(4, 15);
            end
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Stops offering and waits until every predicted line word has come out, then lets
    // the block sit quiet for the settle time so that it is idle for a register write.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register and returns at the accepting edge with valid still high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Writes all five registers back to back; valid drops once after the last one.
    task automatic write_cfg_set(input logic [7:0] flag, input logic [7:0] esc,
                                 input logic [7:0] mask, input logic [7:0] addr,
                                 input logic [7:0] ctrl);
        write_reg(CFG_FLAG_BYTE, flag);
        write_reg(CFG_ESCAPE_BYTE, esc);
        write_reg(CFG_ESCAPE_MASK, mask);
        write_reg(CFG_ADDRESS_BYTE, addr);
        write_reg(CFG_CONTROL_BYTE, ctrl);
        i_cfg_valid <= 1'b0;
        cur_flag = flag;
        cur_esc  = esc;
        cur_mask = mask;
    endtask

    // Register values lean toward the extremes of the byte range.
    function automatic logic [7:0] pick_reg();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Header fields often equal the flag or escape so that the header itself is stuffed.
    function automatic logic [7:0] pick_header(input logic [7:0] flag, input logic [7:0] esc);
        case ($urandom_range(0, 3))
            0:       return flag;
            1:       return esc;
            default: return pick_reg();
        endcase
    endfunction

    // Half of the payload needs stuffing or lands on a collision after the mask.
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0, 1:    return cur_flag;
            2:       return cur_esc;
            3:       return cur_flag ^ cur_mask;
            4:       return cur_esc ^ cur_mask;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Line side: stalls follow segments of varying pattern, from always ready to
    // mostly stalled. Once, well into the random traffic, the line holds off for a
    // long stretch while the sender keeps offering, so the queue fills up and the
    // block has to drop o_ready.
    initial begin : line_sink
        int  mode;
        int  seg_len;
        int  k;
        bit  hold_done;
        hold_done = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(5, 60);
            for (k = 0; k < seg_len; k++) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ((k % 3) == 0);
                endcase
            end
            if (!hold_done && words_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                @(posedge i_clk);
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int         ph;
        int         n;
        logic [7:0] f;
        logic [7:0] e;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values. A single-word frame carries the whole header and the
        // closing flag in one go; the next frame stuffs a flag and an escape and sends
        // the value that a stuffed flag turns into, which must pass untouched.
        send_word(8'h00, 1'b1);
        send_word(8'h7E, 1'b0);
        send_word(8'h7D, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h5E, 1'b1);

        // Open a frame, then change the registers while it is still open. The header
        // already sent stays as it was; the new mask makes both stuffed values collide
        // with the escape and the flag, and they must still go out without a second
        // round of stuffing.
        send_word(8'h11, 1'b0);
        drain();
        write_cfg_set(8'h7E, 8'h7D, 8'h03, 8'h03, 8'h00);
        send_word(8'h7E, 1'b0);
        send_word(8'h7D, 1'b1);

        // Every header byte and the payload need stuffing: ten line words per word.
        drain();
        write_cfg_set(8'h00, 8'h7D, 8'h20, 8'h7D, 8'h7D);
        send_word(8'h00, 1'b1);
        send_word(8'h7D, 1'b1);

        // Flag and escape share one value, with an all-ones mask.
        drain();
        write_cfg_set(8'hAA, 8'hAA, 8'hFF, 8'hFF, 8'h00);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hFF, 1'b1);

        // Extreme values: flag all ones, escape and mask zero.
        drain();
        write_cfg_set(8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h80, 1'b1);

        // Random traffic in phases. The first phase runs the standard register values,
        // the rest draw new ones. A phase may end inside a frame, so register changes
        // in the middle of a frame come up here too.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            if (ph == 0) begin
                write_cfg_set(FLAG_BYTE_RST, ESCAPE_BYTE_RST, ESCAPE_MASK_RST,
                              ADDRESS_BYTE_RST, CONTROL_BYTE_RST);
            end else begin
                f = pick_reg();
                e = ($urandom_range(0, 4) == 0) ? f : pick_reg();
                write_cfg_set(f, e, pick_reg(), pick_header(f, e), pick_header(f, e));
            end
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                send_word(pick_payload(), ($urandom_range(0, 5) == 0));
            end
        end

        // Let every predicted word arrive, then a quiet stretch to catch stray words.
        drain();
        if (mismatches == 0) begin
            $display("PASS byte_stuffed_frame_builder_core");
        end else begin
            $display("FAIL byte_stuffed_frame_builder_core");
        end
        $finish;
    end

endmodule
